// ===== src/ekd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the escape key decoder / cursor tracker.
// No dependencies; every other file of the block refers to this package.
package ekd_pkg;

    localparam int KEY_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 12;

    typedef logic [KEY_W-1:0]   key_code_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COORD_W-1:0] coord_t;

    // Input command codes
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_COL_COUNT = 1'b0,
        CFG_ROW_COUNT = 1'b1
    } cfg_index_t;

    localparam coord_t COLS_RESET = 12'd80;
    localparam coord_t ROWS_RESET = 12'd24;

    // Extended key codes
    localparam key_code_t KEY_ESC   = 9'h01b;
    localparam key_code_t KEY_QUIT  = 9'h011;   // Ctrl-Q
    localparam key_code_t KEY_LEFT  = 9'd256;
    localparam key_code_t KEY_RIGHT = 9'd257;
    localparam key_code_t KEY_UP    = 9'd258;
    localparam key_code_t KEY_DOWN  = 9'd259;
    localparam key_code_t KEY_DEL   = 9'd260;
    localparam key_code_t KEY_HOME  = 9'd261;
    localparam key_code_t KEY_END   = 9'd262;
    localparam key_code_t KEY_PGUP  = 9'd263;
    localparam key_code_t KEY_PGDN  = 9'd264;

    // Request carrying one decoded key between front, queue and back
    typedef struct packed {
        logic      valid;
        key_code_t key;
    } key_req_t;

endpackage

// ===== src/ekd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result requests.
// Depends on ekd_pkg for the payload types.
interface ekd_in_if;
    logic          valid;
    logic          ready;
    logic          command;
    ekd_pkg::byte_t key_byte;

    modport source (output valid, output command, output key_byte, input ready);
    modport sink   (input valid, input command, input key_byte, output ready);
endinterface

interface ekd_out_if;
    logic               valid;
    logic               ready;
    ekd_pkg::key_code_t key_code;
    ekd_pkg::coord_t    cursor_col;
    ekd_pkg::coord_t    cursor_row;
    logic               quit;

    modport source (output valid, output key_code, output cursor_col,
                    output cursor_row, output quit, input ready);
    modport sink   (input valid, input key_code, input cursor_col,
                    input cursor_row, input quit, output ready);
endinterface

// ===== src/ekd_front.sv =====
`timescale 1ns / 1ps
// Front end: escape sequence parser, turns bytes/timeouts into key codes.
// Depends on ekd_pkg.
module ekd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  ekd_pkg::byte_t     key_byte,
    output ekd_pkg::key_req_t  push,
    input  logic               push_ready
);

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_SKIP  = 6'b000100,
        PH_CSI   = 6'b001000,
        PH_SS3   = 6'b010000,
        PH_DIGIT = 6'b100000
    } phase_t;

    localparam ekd_pkg::byte_t CH_ESC   = 8'h1b;
    localparam ekd_pkg::byte_t CH_LBRK  = 8'h5b;  // '['
    localparam ekd_pkg::byte_t CH_SS3   = 8'h4f;  // 'O'
    localparam ekd_pkg::byte_t CH_TILDE = 8'h7e;
    localparam ekd_pkg::byte_t CH_ZERO  = 8'h30;
    localparam ekd_pkg::byte_t CH_NINE  = 8'h39;
    localparam ekd_pkg::byte_t CH_A     = 8'h41;
    localparam ekd_pkg::byte_t CH_B     = 8'h42;
    localparam ekd_pkg::byte_t CH_C     = 8'h43;
    localparam ekd_pkg::byte_t CH_D     = 8'h44;
    localparam ekd_pkg::byte_t CH_H     = 8'h48;
    localparam ekd_pkg::byte_t CH_F     = 8'h46;

    function automatic ekd_pkg::key_code_t csi_letter(input ekd_pkg::byte_t b);
        ekd_pkg::key_code_t k;
        unique case (b)
            CH_A:    k = ekd_pkg::KEY_UP;
            CH_B:    k = ekd_pkg::KEY_DOWN;
            CH_C:    k = ekd_pkg::KEY_RIGHT;
            CH_D:    k = ekd_pkg::KEY_LEFT;
            CH_H:    k = ekd_pkg::KEY_HOME;
            CH_F:    k = ekd_pkg::KEY_END;
            default: k = ekd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic ekd_pkg::key_code_t tilde_digit(input logic [3:0] d);
        ekd_pkg::key_code_t k;
        unique case (d)
            4'd1, 4'd7: k = ekd_pkg::KEY_HOME;
            4'd3:       k = ekd_pkg::KEY_DEL;
            4'd4, 4'd8: k = ekd_pkg::KEY_END;
            4'd5:       k = ekd_pkg::KEY_PGUP;
            4'd6:       k = ekd_pkg::KEY_PGDN;
            default:    k = ekd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    phase_t             phase_reg, phase_next;
    logic [3:0]         digit_reg, digit_next;
    logic               emit;
    ekd_pkg::key_code_t key;
    logic               accept;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        emit       = 1'b0;
        key        = ekd_pkg::KEY_ESC;
        if (command == ekd_pkg::CMD_TIMEOUT)
        begin
            // abandoned sequence gives a bare ESC; idle timeout is silent
            if (phase_reg != PH_IDLE)
            begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    if (key_byte == CH_LBRK)
                        phase_next = PH_CSI;
                    else if (key_byte == CH_SS3)
                        phase_next = PH_SS3;
                    else
                        phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                end
                PH_CSI:
                begin
                    if (key_byte >= CH_ZERO && key_byte <= CH_NINE)
                    begin
                        digit_next = 4'(key_byte - CH_ZERO);
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        key        = csi_letter(key_byte);
                    end
                end
                PH_SS3:
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    if (key_byte == CH_H)
                        key = ekd_pkg::KEY_HOME;
                    else if (key_byte == CH_F)
                        key = ekd_pkg::KEY_END;
                end
                PH_DIGIT:
                begin
                    phase_next = PH_IDLE;
                    emit       = 1'b1;
                    if (key_byte == CH_TILDE)
                        key = tilde_digit(digit_reg);
                end
                default:
                begin
                    // idle, and recovery from any illegal code
                    if (key_byte == CH_ESC)
                        phase_next = PH_ESC;
                    else
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        key        = {1'b0, key_byte};
                    end
                end
            endcase
        end
    end

    assign push.valid = accept && emit;
    assign push.key   = key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            digit_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== src/ekd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry key queue between the parser and the cursor tracker.
// Depends on ekd_pkg.
module ekd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  ekd_pkg::key_req_t push,
    output logic              push_ready,
    output ekd_pkg::key_req_t head,
    input  logic              pop_ready
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    ekd_pkg::key_code_t entry_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]    count_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign do_push    = push.valid && push_ready;
    assign head.valid = (count_reg != '0);
    assign head.key   = entry_reg[rd_ptr_reg];
    assign do_pop     = head.valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("key queue count beyond depth");

    a_pop_changes_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("key queue pop without count drop");

endmodule

// ===== src/ekd_back.sv =====
`timescale 1ns / 1ps
// Back end: applies decoded keys to the cursor, holds the result register
// and the screen size registers. Depends on ekd_pkg.
module ekd_back #(
    parameter int POS_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  ekd_pkg::cfg_index_t cfg_index,
    input  ekd_pkg::coord_t     cfg_data,
    input  ekd_pkg::key_req_t   head,
    output logic                pop_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ekd_pkg::key_code_t  key_code,
    output ekd_pkg::coord_t     cursor_col,
    output ekd_pkg::coord_t     cursor_row,
    output logic                quit
);

    // one bit of headroom over the wider of position and screen size
    localparam int CW = ((POS_BITS > ekd_pkg::COORD_W) ? POS_BITS : ekd_pkg::COORD_W) + 1;
    localparam logic [CW-1:0] PosMax = CW'((1 << POS_BITS) - 1);

    ekd_pkg::coord_t    cols_reg, rows_reg;
    logic [POS_BITS-1:0] col_reg, col_next, row_reg, row_next;
    logic               out_valid_reg;
    ekd_pkg::key_code_t key_reg;
    logic               pop;

    logic [CW-1:0] col_w, row_w, cols_w, rows_w, lc_w, lr_w, col_calc, row_calc;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = head.valid && pop_ready;

    assign col_w  = CW'(col_reg);
    assign row_w  = CW'(row_reg);
    assign cols_w = CW'(cols_reg);
    assign rows_w = CW'(rows_reg);

    always_comb
    begin
        lc_w = '0;
        lr_w = '0;
        if (cols_w != '0)
            lc_w = ((cols_w - 1'b1) > PosMax) ? PosMax : cols_w - 1'b1;
        if (rows_w != '0)
            lr_w = ((rows_w - 1'b1) > PosMax) ? PosMax : rows_w - 1'b1;
    end

    always_comb
    begin
        col_calc = col_w;
        row_calc = row_w;
        unique case (head.key)
            ekd_pkg::KEY_LEFT:
                if (col_w != '0) col_calc = col_w - 1'b1;
            ekd_pkg::KEY_RIGHT:
                if ((col_w + 1'b1) < cols_w && col_w < PosMax) col_calc = col_w + 1'b1;
            ekd_pkg::KEY_UP:
                if (row_w != '0) row_calc = row_w - 1'b1;
            ekd_pkg::KEY_DOWN:
                if ((row_w + 1'b1) < rows_w && row_w < PosMax) row_calc = row_w + 1'b1;
            ekd_pkg::KEY_HOME:
                col_calc = '0;
            ekd_pkg::KEY_END:
                col_calc = lc_w;
            ekd_pkg::KEY_PGUP:
                row_calc = (row_w >= rows_w) ? row_w - rows_w : '0;
            ekd_pkg::KEY_PGDN:
                if (rows_w != '0 && row_w < lr_w) row_calc = lr_w;
            default:
                ;
        endcase
    end

    assign col_next = POS_BITS'(col_calc);
    assign row_next = POS_BITS'(row_calc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= ekd_pkg::COLS_RESET;
            rows_reg      <= ekd_pkg::ROWS_RESET;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ekd_pkg::CFG_COL_COUNT: cols_reg <= cfg_data;
                    ekd_pkg::CFG_ROW_COUNT: rows_reg <= cfg_data;
                endcase
            end
            if (pop)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (pop_ready)
                out_valid_reg <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            key_reg <= head.key;
    end

    // cursor only moves on a pop, which needs a free result slot
    assign out_valid  = out_valid_reg;
    assign key_code   = key_reg;
    assign cursor_col = col_w[ekd_pkg::COORD_W-1:0];
    assign cursor_row = row_w[ekd_pkg::COORD_W-1:0];
    assign quit       = (key_reg == ekd_pkg::KEY_QUIT);

    a_col_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.key != ekd_pkg::KEY_LEFT && head.key != ekd_pkg::KEY_RIGHT
             && head.key != ekd_pkg::KEY_HOME && head.key != ekd_pkg::KEY_END)
        |=> $stable(col_reg))
        else $error("column moved on a non-column key");

    a_cursor_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("cursor changed under a stalled result");

endmodule

// ===== src/escape_key_decoder_cursor_tracker.sv =====
`timescale 1ns / 1ps
// Escape key decoder with cursor tracker: top level.
// Path: a key-producing request is written into the queue at its accepting edge
// and moves on into the result register when the back end pops it; a stalled
// result holds it in the queue. Throughput: one request per cycle while the
// queue has room to take a push; swallowed sequence bytes produce no result.
// Reset (rst_n, async, active low): parser idle, cursor at 0,0, 80x24 screen.
module escape_key_decoder_cursor_tracker #(
    parameter int POS_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration: index 0 column count, index 1 row count
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  ekd_pkg::coord_t  cfg_data,
    ekd_in_if.sink           key_in,
    ekd_out_if.source        key_out
);

    // Front parser pushes decoded keys; the queue lets the parser keep
    // taking bytes while the cursor side waits on a stalled result.
    ekd_pkg::key_req_t push;
    ekd_pkg::key_req_t head;
    logic              push_ready;
    logic              pop_ready;
    logic              front_ready;

    assign key_in.ready = front_ready;

    ekd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (key_in.valid),
        .in_ready   (front_ready),
        .command    (key_in.command),
        .key_byte   (key_in.key_byte),
        .push       (push),
        .push_ready (push_ready)
    );

    ekd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop_ready  (pop_ready)
    );

    // Back end owns the screen size, the cursor and the result register;
    // the cursor reported is the one after the key was applied.
    ekd_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (ekd_pkg::cfg_index_t'(cfg_index)),
        .cfg_data   (cfg_data),
        .head       (head),
        .pop_ready  (pop_ready),
        .out_valid  (key_out.valid),
        .out_ready  (key_out.ready),
        .key_code   (key_out.key_code),
        .cursor_col (key_out.cursor_col),
        .cursor_row (key_out.cursor_row),
        .quit       (key_out.quit)
    );

endmodule
